// ----- hw/rtl/etf_pkg.sv -----
// etf_pkg: shared types, constants and saturation helper for the escape-time pixel block
// no dependencies; imported by every etf module and by the top level
`default_nettype none

package etf_pkg;

  // fixed point format and field widths
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 10;
  localparam int Q_BITS     = 32;
  localparam int STEP_BITS  = 31;
  localparam int PROD_BITS  = COORD_BITS + STEP_BITS;

  // |z|^2 escape bound, 4.0 in the fixed point format
  localparam logic [Q_BITS:0] ESC_LIMIT = (Q_BITS + 1)'(4) << FRAC_BITS;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  // depth of the job queue between front and back, a power of two
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  typedef enum logic [2:0] {
    REG_MIN_RE   = 3'd0,
    REG_MAX_IM   = 3'd1,
    REG_STEP_RE  = 3'd2,
    REG_STEP_IM  = 3'd3,
    REG_JULIA_RE = 3'd4,
    REG_JULIA_IM = 3'd5,
    REG_MAX_ITER = 3'd6,
    REG_MODE     = 3'd7
  } etf_reg_t;

  typedef enum logic {
    MODE_MANDEL = 1'b0,
    MODE_JULIA  = 1'b1
  } etf_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } etf_state_t;

  typedef struct packed {
    logic signed [Q_BITS-1:0] min_re;
    logic signed [Q_BITS-1:0] max_im;
    logic [STEP_BITS-1:0]     step_re;
    logic [STEP_BITS-1:0]     step_im;
    logic signed [Q_BITS-1:0] julia_re;
    logic signed [Q_BITS-1:0] julia_im;
    logic [ITER_BITS-1:0]     max_iter;
    etf_mode_t                mode;
  } etf_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } etf_pixel_t;

  typedef struct packed {
    logic [ITER_BITS-1:0]  iteration_count;
    logic                  escaped;
    logic [COORD_BITS-1:0] col_out;
    logic [COORD_BITS-1:0] row_out;
  } etf_result_t;

  // one classified pixel, ready for the iteration engine
  typedef struct packed {
    logic signed [Q_BITS-1:0] zr;
    logic signed [Q_BITS-1:0] zi;
    logic signed [Q_BITS-1:0] cr;
    logic signed [Q_BITS-1:0] ci;
    logic [ITER_BITS-1:0]     n0;
    logic [COORD_BITS-1:0]    col;
    logic [COORD_BITS-1:0]    row;
  } etf_job_t;

  // clamp a wide signed value to the 32-bit fixed point range
  function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [63:0] x);
    logic signed [Q_BITS-1:0] r;
    if (x > Q_MAX) begin
      r = Q_MAX[Q_BITS-1:0];
    end else if (x < Q_MIN) begin
      r = Q_MIN[Q_BITS-1:0];
    end else begin
      r = x[Q_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/etf_front.sv -----
// etf_front: accepts pixel requests, maps them to the complex plane and classifies by mode
// depends on etf_pkg
`default_nettype none

module etf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire etf_pkg::etf_cfg_t cfg,
  input  wire logic              push,
  output logic                   full,
  input  wire etf_pkg::etf_pixel_t pixel,
  output logic                   q_push,
  input  wire logic              q_full,
  output etf_pkg::etf_job_t      job
);
  import etf_pkg::*;

  logic                  valid;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [PROD_BITS-1:0]  prod_re;
  logic [PROD_BITS-1:0]  prod_im;

  logic load;
  logic signed [Q_BITS-1:0] px_re;
  logic signed [Q_BITS-1:0] px_im;

  assign full   = valid & q_full;
  assign load   = push & ~full;
  assign q_push = valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= load | (valid & q_full);
    end
  end

  // offsets along each axis, registered before the add
  always_ff @(posedge clk) begin
    if (load) begin
      col     <= pixel.col;
      row     <= pixel.row;
      prod_re <= PROD_BITS'(pixel.col) * PROD_BITS'(cfg.step_re);
      prod_im <= PROD_BITS'(pixel.row) * PROD_BITS'(cfg.step_im);
    end
  end

  always_comb begin
    px_re = sat_q(64'(cfg.min_re) + $signed(64'(prod_re)));
    px_im = sat_q(64'(cfg.max_im) - $signed(64'(prod_im)));
    job.zr  = px_re;
    job.zi  = px_im;
    job.col = col;
    job.row = row;
    if (cfg.mode == MODE_JULIA) begin
      job.cr = cfg.julia_re;
      job.ci = cfg.julia_im;
      job.n0 = '0;
    end else begin
      job.cr = px_re;
      job.ci = px_im;
      job.n0 = ITER_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/etf_queue.sv -----
// etf_queue: short first-in first-out job queue between front and back
// depends on etf_pkg
`default_nettype none

module etf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire etf_pkg::etf_job_t wr_data,
  input  wire logic          pop,
  output logic               empty,
  output etf_pkg::etf_job_t  rd_data
);
  import etf_pkg::*;

  etf_job_t             entry [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr;
  logic [JOBQ_AW-1:0]   rd_ptr;
  logic [JOBQ_AW:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == (JOBQ_AW + 1)'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + JOBQ_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + JOBQ_AW'(1);
      if (do_push & ~do_pop) begin
        count <= count + (JOBQ_AW + 1)'(1);
      end else if (do_pop & ~do_push) begin
        count <= count - (JOBQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/etf_iter.sv -----
// etf_iter: escape-time iteration engine with a one-entry result register
// depends on etf_pkg
`default_nettype none

module etf_iter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [etf_pkg::ITER_BITS-1:0] max_iter,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire etf_pkg::etf_job_t job,
  output logic                   empty,
  input  wire logic              pop,
  output etf_pkg::etf_result_t   result
);
  import etf_pkg::*;

  etf_state_t state;
  etf_state_t state_next;

  logic signed [Q_BITS-1:0] zr;
  logic signed [Q_BITS-1:0] zi;
  logic signed [Q_BITS-1:0] cr;
  logic signed [Q_BITS-1:0] ci;
  logic [ITER_BITS-1:0]     n;
  logic [COORD_BITS-1:0]    col;
  logic [COORD_BITS-1:0]    row;
  logic signed [63:0]       p_rr;
  logic signed [63:0]       p_ii;
  logic signed [63:0]       p_ri;
  logic                     res_valid;

  logic signed [63:0]       mul_rr;
  logic signed [63:0]       mul_ii;
  logic signed [63:0]       mul_ri;
  logic signed [Q_BITS-1:0] zr2;
  logic signed [Q_BITS-1:0] zi2;
  logic [Q_BITS:0]          mag;
  logic                     esc;
  logic                     stop;
  logic signed [Q_BITS-1:0] nr;
  logic signed [Q_BITS-1:0] ni;
  logic                     load;
  logic                     mul_en;
  logic                     step;
  logic                     finish;

  assign empty = ~res_valid;

  always_comb begin
    mul_rr = zr * zr;
    mul_ii = zi * zi;
    mul_ri = zr * zi;
    zr2  = sat_q(p_rr >>> FRAC_BITS);
    zi2  = sat_q(p_ii >>> FRAC_BITS);
    // squares are never negative, so zero extension is exact
    mag  = {1'b0, zr2} + {1'b0, zi2};
    esc  = (mag > ESC_LIMIT);
    stop = (n >= max_iter) | esc;
    nr   = sat_q(64'(zr2) - 64'(zi2) + 64'(cr));
    // cross term doubled by shifting one bit less
    ni   = sat_q((p_ri >>> (FRAC_BITS - 1)) + 64'(ci));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    mul_en     = 1'b0;
    step       = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          load       = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stop) begin
          // hold here until the result register can take the value
          if (!res_valid || pop) begin
            finish = 1'b1;
            if (!q_empty) begin
              q_pop      = 1'b1;
              load       = 1'b1;
              state_next = ST_MUL;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          step       = 1'b1;
          state_next = ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      zr  <= job.zr;
      zi  <= job.zi;
      cr  <= job.cr;
      ci  <= job.ci;
      n   <= job.n0;
      col <= job.col;
      row <= job.row;
    end else if (step) begin
      zr <= nr;
      zi <= ni;
      n  <= n + ITER_BITS'(1);
    end
    if (mul_en) begin
      p_rr <= mul_rr;
      p_ii <= mul_ii;
      p_ri <= mul_ri;
    end
    if (finish) begin
      result.iteration_count <= n;
      result.escaped         <= esc;
      result.col_out         <= col;
      result.row_out         <= row;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/escape_time_fractal_pixel.sv -----
// escape_time_fractal_pixel: top level with configuration registers, front, job queue and engine
// depends on etf_pkg, etf_front, etf_queue, etf_iter
//
// usage
//   pixel requests enter on push/full with pixel.col and pixel.row; a request is taken
//   at a clock edge where push is high and full is low
//   results leave in request order on empty/pop; result holds the oldest finished pixel
//   while empty is low and is consumed at an edge where pop is high
//   configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, and writes are expected only while no request is in flight
// timing
//   the front registers the mapped pixel, then the job waits in a two-entry queue
//   the engine loads a job and then loops through a multiply state and an update and
//   test state until the pixel stops; it works on one pixel at a time, so throughput
//   is set by that loop
// reset
//   rst clears all queues and the engine and loads the default view and limit
// stalls
//   a finished result waits in the output register; the engine keeps it until pop and
//   then starts the next queued job, while the front keeps filling the queue
`default_nettype none

module escape_time_fractal_pixel (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire etf_pkg::etf_pixel_t  pixel,
  output logic                      empty,
  input  wire logic                 pop,
  output etf_pkg::etf_result_t      result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import etf_pkg::*;

  etf_cfg_t cfg;

  logic     fq_push;
  logic     fq_full;
  etf_job_t fq_data;
  logic     qi_pop;
  logic     qi_empty;
  etf_job_t qi_data;

  // configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_re   <= -32'sd536870912;
      cfg.max_im   <= 32'sd536870912;
      cfg.step_re  <= STEP_BITS'(1048576);
      cfg.step_im  <= STEP_BITS'(1048576);
      cfg.julia_re <= '0;
      cfg.julia_im <= '0;
      cfg.max_iter <= ITER_BITS'(100);
      cfg.mode     <= MODE_MANDEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (etf_reg_t'(cfg_index))
        REG_MIN_RE:   cfg.min_re   <= $signed(cfg_data);
        REG_MAX_IM:   cfg.max_im   <= $signed(cfg_data);
        REG_STEP_RE:  cfg.step_re  <= cfg_data[STEP_BITS-1:0];
        REG_STEP_IM:  cfg.step_im  <= cfg_data[STEP_BITS-1:0];
        REG_JULIA_RE: cfg.julia_re <= $signed(cfg_data);
        REG_JULIA_IM: cfg.julia_im <= $signed(cfg_data);
        REG_MAX_ITER: cfg.max_iter <= cfg_data[ITER_BITS-1:0];
        REG_MODE:     cfg.mode     <= etf_mode_t'(cfg_data[0]);
      endcase
    end
  end

  // front: coordinate mapping and mode classification
  etf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_push (fq_push),
    .q_full (fq_full),
    .job    (fq_data)
  );

  // decouples mapping from iteration
  etf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_data),
    .pop     (qi_pop),
    .empty   (qi_empty),
    .rd_data (qi_data)
  );

  // back: z = z^2 + c loop and result register
  etf_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .max_iter (cfg.max_iter),
    .q_empty  (qi_empty),
    .q_pop    (qi_pop),
    .job      (qi_data),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for the escape-time fractal pixel block
// depends on etf_pkg and escape_time_fractal_pixel; predicts every pixel count in fixed point
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import etf_pkg::*;

  localparam int     CYCLE_LIMIT  = 2_000_000;
  localparam int     DRAIN_CYCLES = 64;
  localparam longint ESCAPE_BOUND = longint'(4) << FRAC_BITS;

  logic        clk;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  etf_pixel_t  pixel     = '0;
  logic        empty;
  logic        pop       = 1'b0;
  etf_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // shadow of the configuration registers, updated once all eight writes of a view are sent
  etf_cfg_t    view;
  // predicted results, oldest first, in request order
  etf_result_t results_due[$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int mismatches = 0;
  int cycle_count = 0;

  escape_time_fractal_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  // clamp to the signed 32-bit fixed point range
  function automatic longint clamp_q(input longint x);
    if (x > Q_MAX) begin
      return Q_MAX;
    end else if (x < Q_MIN) begin
      return Q_MIN;
    end
    return x;
  endfunction

  // exact product, floor shift by the fraction bits, then clamp
  function automatic longint fixed_mul(input longint a, input longint b);
    return clamp_q((a * b) >>> FRAC_BITS);
  endfunction

  // escape-time count of one pixel under the current register view
  function automatic etf_result_t predict_pixel(input etf_pixel_t px);
    longint      col_w, row_w;
    longint      cr, ci, zr, zi, zr2, zi2;
    int unsigned n;
    logic        esc;
    etf_result_t r;
    col_w = longint'(px.col);
    row_w = longint'(px.row);
    zr = clamp_q(longint'(view.min_re) + col_w * longint'(view.step_re));
    zi = clamp_q(longint'(view.max_im) - row_w * longint'(view.step_im));
    if (view.mode == MODE_JULIA) begin
      cr = longint'(view.julia_re);
      ci = longint'(view.julia_im);
      n  = 0;
    end else begin
      cr = zr;
      ci = zi;
      n  = 1;
    end
    forever begin
      zr2 = fixed_mul(zr, zr);
      zi2 = fixed_mul(zi, zi);
      // |z|^2 is the plain sum of the clamped squares, no clamp on the sum
      esc = (zr2 + zi2) > ESCAPE_BOUND;
      if (n >= view.max_iter || esc) break;
      // new real part goes through zr2 so the cross term still sees the old zr
      zr2 = clamp_q(zr2 - zi2 + cr);
      zi  = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr  = zr2;
      n++;
    end
    r.iteration_count = ITER_BITS'(n);
    r.escaped         = esc;
    r.col_out         = px.col;
    r.row_out         = px.row;
    return r;
  endfunction

  // ---------------------------------------------------------------- result check

  task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every popped result is held against the oldest prediction
  always @(posedge clk) begin
    etf_result_t want;
    if (!rst && pop && !empty) begin
      if (results_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual count %0d esc %0b at (%0d,%0d)",
                 $time, result.iteration_count, result.escaped, result.col_out,
                 result.row_out);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        report_field("iteration_count", 16'(want.iteration_count),
                     16'(result.iteration_count));
        report_field("escaped", 16'(want.escaped), 16'(result.escaped));
        report_field("col_out", 16'(want.col_out), 16'(result.col_out));
        report_field("row_out", 16'(want.row_out), 16'(result.row_out));
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // long hold-off, counted down on its own
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // pop at random, never while a hold-off is running
  always @(posedge clk) begin
    pop <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- request side

  // one pixel request; push stays high afterward so back-to-back requests never glitch it
  task automatic send_pixel(input logic [COORD_BITS-1:0] c, input logic [COORD_BITS-1:0] r);
    etf_pixel_t px;
    px.col = c;
    px.row = r;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    results_due.push_back(predict_pixel(px));
  endtask

  // drop push and let every outstanding pixel come back
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic etf_cfg_t make_view(input logic [31:0] min_re, input logic [31:0] max_im,
                                         input logic [30:0] step_re, input logic [30:0] step_im,
                                         input logic [31:0] julia_re, input logic [31:0] julia_im,
                                         input logic [9:0] max_iter, input etf_mode_t mode);
    etf_cfg_t v;
    v.min_re   = min_re;
    v.max_im   = max_im;
    v.step_re  = step_re;
    v.step_im  = step_im;
    v.julia_re = julia_re;
    v.julia_im = julia_im;
    v.max_iter = max_iter;
    v.mode     = mode;
    return v;
  endfunction

  // write all eight registers; unused upper data bits carry random junk
  task automatic apply_view(input etf_cfg_t v);
    logic [31:0] data [8];
    data[REG_MIN_RE]   = v.min_re;
    data[REG_MAX_IM]   = v.max_im;
    data[REG_STEP_RE]  = {1'($urandom), v.step_re};
    data[REG_STEP_IM]  = {1'($urandom), v.step_im};
    data[REG_JULIA_RE] = v.julia_re;
    data[REG_JULIA_IM] = v.julia_im;
    data[REG_MAX_ITER] = {22'($urandom), v.max_iter};
    data[REG_MODE]     = {31'($urandom), v.mode};
    for (int i = 0; i <= REG_MODE; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= etf_reg_t'(i);
      cfg_data  <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    view = v;
  endtask

  // mostly a window around the set with a modest limit, sometimes a wild window
  function automatic etf_cfg_t random_view();
    etf_cfg_t v;
    v.min_re   = -32'sd671088640 + $urandom_range(805306368);
    v.max_im   = -32'sd134217728 + $urandom_range(536870912);
    v.step_re  = STEP_BITS'($urandom_range(1 << 24, 1 << 21));
    v.step_im  = STEP_BITS'($urandom_range(1 << 24, 1 << 21));
    v.julia_re = $urandom_range(1 << 29) - (1 << 28);
    v.julia_im = $urandom_range(1 << 29) - (1 << 28);
    v.max_iter = ITER_BITS'(($urandom_range(19) == 0) ? $urandom_range(255)
                                                      : $urandom_range(64, 1));
    v.mode     = etf_mode_t'($urandom_range(1));
    if ($urandom_range(7) == 0) begin
      v.min_re  = $urandom;
      v.max_im  = $urandom;
      v.step_re = STEP_BITS'($urandom);
      v.step_im = STEP_BITS'($urandom);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- tests

  // registers untouched since reset: corners, alternating bits and the pixel at (128, 128)
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd128, 12'd128);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    wait_idle();
  endtask

  // register extremes, coordinate clamping in both directions, both stop conditions at once
  task automatic test_extremes();
    apply_view(make_view(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 10'd1, MODE_MANDEL));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd1, 12'd1);
    wait_idle();
    // zero steps pin every pixel to the origin, huge c escapes after one pass
    apply_view(make_view(32'd0, 32'd0, 31'd0, 31'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                         10'd1023, MODE_JULIA));
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    wait_idle();
  endtask

  // zero limit in both modes, then the full limit in both modes at pixel (128, 128)
  task automatic test_iteration_limits();
    apply_view(make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                         32'd0, 32'd0, 10'd0, MODE_MANDEL));
    send_pixel(12'd128, 12'd128);
    send_pixel(12'hFFF, 12'd0);
    wait_idle();
    apply_view(make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                         32'd0, 32'd0, 10'd0, MODE_JULIA));
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd0, 12'd0);
    wait_idle();
    apply_view(make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                         32'd0, 32'd0, 10'd1023, MODE_MANDEL));
    send_pixel(12'd128, 12'd128);
    wait_idle();
    apply_view(make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                         32'd0, 32'd0, 10'd1023, MODE_JULIA));
    send_pixel(12'd128, 12'd128);
    wait_idle();
  endtask

  // a classic connected Julia constant over a small tile
  task automatic test_julia_constant();
    apply_view(make_view(-32'sd402653184, 32'sd268435456, 31'd12582912, 31'd8388608,
                         -32'sd214748365, 32'sd41875931, 10'd200, MODE_JULIA));
    send_pixel(12'd10, 12'd20);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd50, 12'd5);
    send_pixel(12'd63, 12'd63);
    wait_idle();
  endtask

  // result side stops for a long stretch so the block fills and holds off requests
  task automatic test_backpressure();
    apply_view(make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                         32'd0, 32'd0, 10'd6, MODE_MANDEL));
    hold_left <= 2000;
    repeat (16) send_pixel(COORD_BITS'($urandom_range(255)), COORD_BITS'($urandom_range(255)));
    wait_idle();
  endtask

  // random windows and pixels, mostly inside a small tile, under one idling pattern
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    idle_pct  = idle;
    stall_pct <= stall;
    for (int b = 0; b < count / 25; b++) begin
      wait_idle();
      apply_view(random_view());
      repeat (25) begin
        if ($urandom_range(6) == 0) begin
          send_pixel(COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)));
        end else begin
          send_pixel(COORD_BITS'($urandom_range(63)), COORD_BITS'($urandom_range(63)));
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    view = make_view(-32'sd536870912, 32'sd536870912, 31'd1048576, 31'd1048576,
                     32'd0, 32'd0, 10'd100, MODE_MANDEL);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_extremes();
    test_iteration_limits();
    test_julia_constant();
    test_backpressure();
    test_random_traffic(0, 0, 125);
    test_random_traffic(61, 0, 125);
    test_random_traffic(0, 61, 125);
    test_random_traffic(21, 21, 125);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/etf_pkg.sv
hw/rtl/etf_front.sv
hw/rtl/etf_queue.sv
hw/rtl/etf_iter.sv
hw/rtl/escape_time_fractal_pixel.sv
sim/tb_top.sv
